### rtl/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types, constants and pixel math for the RGB555 pixel shader.
// ----------------------------------------------------------------------------
package rps_pkg;

  localparam int ROW_BITS     = 10;
  localparam int ROWS         = 512;
  localparam int ROW_SEL_BITS = $clog2(ROWS);
  localparam int AW           = ROW_BITS + ROW_SEL_BITS;
  localparam int MEM_WORDS    = ROWS << ROW_BITS;
  localparam int QDEPTH       = 2;

  // configuration register indexes
  localparam logic [2:0] REG_SHADE_MODE    = 3'd0;
  localparam logic [2:0] REG_BLEND_OP      = 3'd1;
  localparam logic [2:0] REG_TEXTURE_DEPTH = 3'd2;
  localparam logic [2:0] REG_TEXTURE_BASE  = 3'd3;
  localparam logic [2:0] REG_CLUT_BASE     = 3'd4;
  localparam logic [2:0] REG_WINDOW_MASK   = 3'd5;
  localparam logic [2:0] REG_LIGHT_COLOUR  = 3'd6;
  localparam logic [2:0] REG_SET_MASK      = 3'd7;

  // shade_mode bits
  localparam int SM_NO_LIGHT = 0;
  localparam int SM_BLEND    = 1;
  localparam int SM_TEXTURE  = 2;
  localparam int SM_MASK     = 3;

  localparam logic [1:0] BLEND_AVG  = 2'd0;
  localparam logic [1:0] BLEND_ADD  = 2'd1;
  localparam logic [1:0] BLEND_SUB  = 2'd2;
  localparam logic [1:0] BLEND_QTR  = 2'd3;

  localparam logic [1:0] DEPTH_4    = 2'd0;
  localparam logic [1:0] DEPTH_8    = 2'd1;
  localparam logic [1:0] DEPTH_15   = 2'd2;
  localparam logic [1:0] DEPTH_4ALT = 2'd3;

  localparam logic [15:0] MASK_AVG = 16'h7BDE;
  localparam logic [15:0] MASK_B   = 16'h7C00;
  localparam logic [15:0] MASK_G   = 16'h03E0;
  localparam logic [15:0] MASK_R   = 16'h001F;
  localparam logic [15:0] BIT_MSK  = 16'h8000;
  localparam logic [15:0] MASK_RGB = 16'h7FFF;
  localparam logic [15:0] QTR_B    = 16'h1C00;
  localparam logic [15:0] QTR_G    = 16'h00E0;
  localparam logic [15:0] QTR_R    = 16'h0007;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDOUT,
    ST_CHK,
    ST_TEX,
    ST_PAL,
    ST_SHADE
  } st_t;

  typedef struct packed {
    logic [3:0]  shade_mode;
    logic [1:0]  blend_op;
    logic [1:0]  texture_depth;
    logic [18:0] texture_base;
    logic [14:0] clut_base;
    logic [15:0] window_mask;
    logic [23:0] light_colour;
    logic        set_mask;
  } cfg_t;

  // one queued transaction, already classified
  typedef struct packed {
    op_t          op;
    logic [AW-1:0] addr;
    logic [7:0]   u;
    logic [7:0]   v;
    logic [15:0]  colour;
  } item_t;

  function automatic logic [4:0] light_ch(input logic [4:0] c, input logic [7:0] l);
    logic [12:0] p;
    p = 13'(c) * 13'(l);
    light_ch = (p[12:7] > 6'd31) ? 5'd31 : p[11:7];
  endfunction

  function automatic logic [15:0] apply_light(input logic [15:0] p, input logic [23:0] l);
    apply_light = {p[15], light_ch(p[14:10], l[23:16]), light_ch(p[9:5], l[15:8]),
                   light_ch(p[4:0], l[7:0])};
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] m);
    logic [16:0] s;
    s = 17'(a & m) + 17'(b & m);
    sat_add = (s > 17'(m)) ? m : s[15:0];
  endfunction

  function automatic logic [15:0] clamp_sub(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] m);
    clamp_sub = ((a & m) >= (b & m)) ? ((a & m) - (b & m)) : 16'd0;
  endfunction

  function automatic logic [15:0] blend(input logic [1:0] op, input logic [15:0] bk,
                                        input logic [15:0] fr);
    logic [16:0] s;
    logic [15:0] q;
    s = 17'(bk & MASK_AVG) + 17'(fr & MASK_AVG);
    q = fr >> 2;
    case (op)
      BLEND_AVG: blend = s[16:1];
      BLEND_ADD: blend = sat_add(bk, fr, MASK_B) | sat_add(bk, fr, MASK_G)
                       | sat_add(bk, fr, MASK_R);
      BLEND_SUB: blend = clamp_sub(bk, fr, MASK_B) | clamp_sub(bk, fr, MASK_G)
                       | clamp_sub(bk, fr, MASK_R);
      default:   blend = sat_add(bk, q & QTR_B, MASK_B) | sat_add(bk, q & QTR_G, MASK_G)
                       | sat_add(bk, q & QTR_R, MASK_R);
    endcase
  endfunction

endpackage

### rtl/rps_front.sv
// ----------------------------------------------------------------------------
// rps_front
// Accepts transactions, forms the pixel address and windowed texture
// coordinates, and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module rps_front import rps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [9:0]  in_pos_x,
  input  logic [8:0]  in_pos_y,
  input  logic [7:0]  in_tex_u,
  input  logic [7:0]  in_tex_v,
  input  logic [15:0] in_colour,
  output logic        q_valid,
  input  logic        q_pop,
  output item_t       q_data
);

  localparam int PW = $clog2(QDEPTH);

  item_t              ent_r [QDEPTH];
  logic [PW-1:0]      wp_r, rp_r;
  logic [PW:0]        cnt_r;
  item_t              item;
  logic               push;

  always_comb begin
    item.op     = op_t'(in_opcode);
    item.addr   = (AW'(in_pos_y) << ROW_BITS) + AW'(in_pos_x);
    item.u      = in_tex_u & cfg.window_mask[7:0];
    item.v      = in_tex_v & cfg.window_mask[15:8];
    item.colour = in_colour;
  end

  assign in_ready = (cnt_r != (PW+1)'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_data   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end

endmodule

### rtl/rps_back.sv
// ----------------------------------------------------------------------------
// rps_back
// Sequencer over the single-port frame memory: destination, texel and
// palette reads, shading, write-back and the result register.
// ----------------------------------------------------------------------------
module rps_back import rps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  output logic        q_pop,
  input  item_t       q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_data,
  output logic        out_stored
);

  logic [15:0]   mem_q [MEM_WORDS];
  logic [15:0]   rdata_r;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata;

  st_t           st_r, st_nxt;
  item_t         cur_r, cur_nxt;
  logic [15:0]   bk_r, bk_nxt, px_r, px_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_data_r, out_data_nxt;
  logic          out_stored_r, out_stored_nxt;

  logic          out_free, textured;
  logic [7:0]    col;
  logic [7:0]    idx;
  logic [15:0]   lit, res;

  always_ff @(posedge clk) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    if (mem_re) rdata_r <= mem_q[mem_addr];
  end

  assign out_free = !out_valid_r || out_ready;
  assign textured = cfg.shade_mode[SM_TEXTURE];

  always_comb begin
    case (cfg.texture_depth)
      DEPTH_8:  col = cur_r.u >> 1;
      DEPTH_15: col = cur_r.u;
      default:  col = cur_r.u >> 2;
    endcase
    if (cfg.texture_depth == DEPTH_8) begin
      idx = 8'(rdata_r >> {cur_r.u[0], 3'b000});
    end else begin
      idx = {4'd0, 4'(rdata_r >> {cur_r.u[1:0], 2'b00})};
    end
    lit = cfg.shade_mode[SM_NO_LIGHT] ? px_r : apply_light(px_r, cfg.light_colour);
    if (cfg.shade_mode[SM_BLEND] && (!textured || lit[15])) begin
      res = blend(cfg.blend_op, bk_r, lit);
    end else begin
      res = lit & MASK_RGB;
    end
    res = (res & MASK_RGB) | (cfg.set_mask ? BIT_MSK : 16'd0);
  end

  always_comb begin
    st_nxt         = st_r;
    cur_nxt        = cur_r;
    bk_nxt         = bk_r;
    px_nxt         = px_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_stored_nxt = out_stored_r;
    q_pop          = 1'b0;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = cur_r.addr;
    mem_wdata      = res;
    case (st_r)
      ST_IDLE: begin
        mem_addr = q_data.addr;
        if (q_valid) begin
          case (q_data.op)
            OP_DRAW, OP_READ: begin
              q_pop   = 1'b1;
              mem_re  = 1'b1;
              cur_nxt = q_data;
              st_nxt  = (q_data.op == OP_DRAW) ? ST_CHK : ST_RDOUT;
            end
            OP_WRITE: begin
              if (out_free) begin
                q_pop          = 1'b1;
                mem_we         = 1'b1;
                mem_wdata      = q_data.colour;
                out_valid_nxt  = 1'b1;
                out_data_nxt   = q_data.colour;
                out_stored_nxt = 1'b1;
              end
            end
            default: begin
              if (out_free) begin
                q_pop          = 1'b1;
                out_valid_nxt  = 1'b1;
                out_data_nxt   = 16'd0;
                out_stored_nxt = 1'b0;
              end
            end
          endcase
        end
      end
      ST_RDOUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = rdata_r;
          out_stored_nxt = 1'b0;
          st_nxt         = ST_IDLE;
        end
      end
      ST_CHK: begin
        bk_nxt = rdata_r;
        if (cfg.shade_mode[SM_MASK] && rdata_r[15]) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_data_nxt   = 16'd0;
            out_stored_nxt = 1'b0;
            st_nxt         = ST_IDLE;
          end
        end else if (textured) begin
          mem_re   = 1'b1;
          mem_addr = AW'(cfg.texture_base) + (AW'(cur_r.v) << ROW_BITS) + AW'(col);
          st_nxt   = ST_TEX;
        end else begin
          px_nxt = cur_r.colour;
          st_nxt = ST_SHADE;
        end
      end
      ST_TEX: begin
        if (cfg.texture_depth == DEPTH_15) begin
          px_nxt = rdata_r;
          st_nxt = ST_SHADE;
        end else begin
          mem_re   = 1'b1;
          mem_addr = (AW'(cfg.clut_base) << 4) + AW'(idx);
          st_nxt   = ST_PAL;
        end
      end
      ST_PAL: begin
        px_nxt = rdata_r;
        st_nxt = ST_SHADE;
      end
      ST_SHADE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
          if (textured && px_r == 16'd0) begin
            // transparent texel
            out_data_nxt   = 16'd0;
            out_stored_nxt = 1'b0;
          end else begin
            mem_we         = 1'b1;
            out_data_nxt   = res;
            out_stored_nxt = 1'b1;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    bk_r         <= bk_nxt;
    px_r         <= px_nxt;
    out_data_r   <= out_data_nxt;
    out_stored_r <= out_stored_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_stored = out_stored_r;

endmodule

### rtl/rgb555_pixel_shader.sv
// ----------------------------------------------------------------------------
// rgb555_pixel_shader
// Per-pixel shading stage of an RGB555 rasterizer over its own frame memory.
// ----------------------------------------------------------------------------
// Transactions enter a two-entry queue and are executed one at a time by a
// sequencer on a single-port frame memory. A raw write or an unused opcode
// reads nothing and a read fetches one word. A draw reads the destination,
// then for a textured draw the texel word and, at CLUT depths, the palette
// entry, and ends with the write-back unless the texel is transparent. A draw
// skipped by the mask check writes nothing. The frame memory is not cleared at
// reset and must be loaded with write transactions before it is read.
module rgb555_pixel_shader import rps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [9:0]  in_pos_x,
  input  logic [8:0]  in_pos_y,
  input  logic [7:0]  in_tex_u,
  input  logic [7:0]  in_tex_v,
  input  logic [15:0] in_colour,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_data,
  output logic        out_stored
);

  cfg_t  cfg_r;
  logic  q_valid, q_pop;
  item_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shade_mode    <= 4'd1;
      cfg_r.blend_op      <= BLEND_AVG;
      cfg_r.texture_depth <= DEPTH_4;
      cfg_r.texture_base  <= '0;
      cfg_r.clut_base     <= '0;
      cfg_r.window_mask   <= 16'hFFFF;
      cfg_r.light_colour  <= 24'h808080;
      cfg_r.set_mask      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHADE_MODE:    cfg_r.shade_mode    <= cfg_wdata[3:0];
        REG_BLEND_OP:      cfg_r.blend_op      <= cfg_wdata[1:0];
        REG_TEXTURE_DEPTH: cfg_r.texture_depth <= cfg_wdata[1:0];
        REG_TEXTURE_BASE:  cfg_r.texture_base  <= cfg_wdata[18:0];
        REG_CLUT_BASE:     cfg_r.clut_base     <= cfg_wdata[14:0];
        REG_WINDOW_MASK:   cfg_r.window_mask   <= cfg_wdata[15:0];
        REG_LIGHT_COLOUR:  cfg_r.light_colour  <= cfg_wdata;
        REG_SET_MASK:      cfg_r.set_mask      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  rps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_pos_x  (in_pos_x),
    .in_pos_y  (in_pos_y),
    .in_tex_u  (in_tex_u),
    .in_tex_v  (in_tex_v),
    .in_colour (in_colour),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data)
  );

  rps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .out_stored (out_stored)
  );

  // a full queue always has something for the back end
  a_full_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("queue full but empty to back end");

  // an accepted transaction is visible to the back end next cycle
  a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> q_valid)
    else $error("accepted transaction lost");

  // the back end never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

### verif/rgb555_pixel_shader_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb555_pixel_shader_tb
// Self-checking bench: drives draw, write, read and unused transactions with
// random handshake gaps, predicts each result from its table or a local
// shading model and its own image of the frame memory, walks the registers
// through several settings and always writes words before they are read.
// ----------------------------------------------------------------------------
module rgb555_pixel_shader_tb;
  import rps_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 42;

  typedef struct {
    logic [15:0] data;
    logic        stored;
  } word_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    op_t         op;
    logic [9:0]  x;
    logic [8:0]  y;
    logic [7:0]  u;
    logic [7:0]  v;
    logic [15:0] colour;
    logic [2:0]  reg_idx;
    logic [23:0] reg_val;
    logic        typed;
    logic [15:0] edata;
    logic        estored;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = OP_NOP;
  logic [9:0]  in_pos_x = '0;
  logic [8:0]  in_pos_y = '0;
  logic [7:0]  in_tex_u = '0;
  logic [7:0]  in_tex_v = '0;
  logic [15:0] in_colour = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_data;
  logic        out_stored;

  rgb555_pixel_shader u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block's state
  logic [15:0] frame_words [int];
  int          written_addrs [$];
  cfg_t        regs;
  word_result_t expected_words [$];
  int  errors = 0;
  int  cycles = 0;
  bit  gaps_on = 1'b1;
  stim_row_t table_rows [$];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rgb555_pixel_shader_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [4:0] scale_channel(logic [4:0] c, logic [7:0] l);
    logic [12:0] p;
    p = {8'd0, c} * {5'd0, l};
    return (p >> 7) > 13'd31 ? 5'd31 : p[11:7];
  endfunction

  function automatic logic [15:0] chan_add(logic [15:0] a, logic [15:0] b, logic [15:0] m);
    logic [16:0] s;
    s = {1'b0, a & m} + {1'b0, b & m};
    return s > {1'b0, m} ? m : s[15:0];
  endfunction

  function automatic logic [15:0] chan_sub(logic [15:0] a, logic [15:0] b, logic [15:0] m);
    return (a & m) >= (b & m) ? (a & m) - (b & m) : 16'd0;
  endfunction

  function automatic logic [15:0] mix_pixel(logic [15:0] bk, logic [15:0] fr);
    logic [16:0] s;
    logic [15:0] q;
    q = fr >> 2;
    case (regs.blend_op)
      BLEND_AVG: begin
        s = {1'b0, bk & MASK_AVG} + {1'b0, fr & MASK_AVG};
        return s[16:1];
      end
      BLEND_ADD: return chan_add(bk, fr, MASK_B) | chan_add(bk, fr, MASK_G)
                      | chan_add(bk, fr, MASK_R);
      BLEND_SUB: return chan_sub(bk, fr, MASK_B) | chan_sub(bk, fr, MASK_G)
                      | chan_sub(bk, fr, MASK_R);
      default:   return chan_add(bk, q & QTR_B, MASK_B) | chan_add(bk, q & QTR_G, MASK_G)
                      | chan_add(bk, q & QTR_R, MASK_R);
    endcase
  endfunction

  // texel word address for the current depth, texture base and window mask
  function automatic logic [18:0] texel_word_addr(logic [7:0] u, logic [7:0] v);
    logic [7:0]  wu, wv;
    logic [18:0] row;
    wu = u & regs.window_mask[7:0];
    wv = v & regs.window_mask[15:8];
    row = regs.texture_base + ({11'd0, wv} << ROW_BITS);
    case (regs.texture_depth)
      DEPTH_15: return row + 19'(wu);
      DEPTH_8:  return row + 19'(wu >> 1);
      default:  return row + 19'(wu >> 2);
    endcase
  endfunction

  function automatic logic [18:0] palette_addr(logic [7:0] u, logic [15:0] w);
    logic [7:0] wu, idx;
    wu = u & regs.window_mask[7:0];
    if (regs.texture_depth == DEPTH_8) idx = 8'(w >> {wu[0], 3'd0});
    else idx = {4'd0, 4'(w >> {wu[1:0], 2'd0})};
    return ({4'd0, regs.clut_base} << 4) + 19'(idx);
  endfunction

  function automatic void store_word(logic [18:0] a, logic [15:0] w);
    if (!frame_words.exists(a)) written_addrs.push_back(a);
    frame_words[a] = w;
  endfunction

  function automatic word_result_t shade_pixel(op_t op, logic [9:0] x, logic [8:0] y,
                                               logic [7:0] u, logic [7:0] v,
                                               logic [15:0] col);
    word_result_t r;
    logic [18:0] a;
    logic [15:0] bk, px, w;
    bit skip;
    r = '{16'd0, 1'b0};
    a = {y, x};
    skip = 1'b0;
    case (op)
      OP_WRITE: begin
        store_word(a, col);
        r = '{col, 1'b1};
      end
      OP_READ: r.data = frame_words[a];
      OP_DRAW: begin
        bk = frame_words[a];
        px = col;
        if (regs.shade_mode[SM_MASK] && bk[15]) skip = 1'b1;
        if (!skip && regs.shade_mode[SM_TEXTURE]) begin
          w = frame_words[texel_word_addr(u, v)];
          px = (regs.texture_depth == DEPTH_15) ? w : frame_words[palette_addr(u, w)];
          if (px == 16'd0) skip = 1'b1;
        end
        if (!skip) begin
          if (!regs.shade_mode[SM_NO_LIGHT])
            px = {px[15], scale_channel(px[14:10], regs.light_colour[23:16]),
                  scale_channel(px[9:5], regs.light_colour[15:8]),
                  scale_channel(px[4:0], regs.light_colour[7:0])};
          if (regs.shade_mode[SM_BLEND] && (!regs.shade_mode[SM_TEXTURE] || px[15]))
            px = mix_pixel(bk, px);
          px = {regs.set_mask, px[14:0]};
          store_word(a, px);
          r = '{px, 1'b1};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------------ drivers
  task automatic send_item(op_t op, logic [9:0] x, logic [8:0] y, logic [7:0] u,
                           logic [7:0] v, logic [15:0] col, bit typed = 1'b0,
                           word_result_t typed_res = '{16'd0, 1'b0});
    word_result_t r;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_opcode = op;
    in_pos_x = x;
    in_pos_y = y;
    in_tex_u = u;
    in_tex_v = v;
    in_colour = col;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    r = shade_pixel(op, x, y, u, v, col);
    expected_words.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic fill_if_blank(logic [18:0] a);
    if (!frame_words.exists(a))
      send_item(OP_WRITE, a[9:0], a[18:10], 8'($urandom), 8'($urandom),
                $urandom_range(0, 7) == 0 ? 16'd0 : 16'($urandom));
  endtask

  // every word the draw may read is loaded first
  task automatic send_draw(logic [9:0] x, logic [8:0] y, logic [7:0] u, logic [7:0] v,
                           logic [15:0] col, bit typed = 1'b0,
                           word_result_t typed_res = '{16'd0, 1'b0});
    logic [18:0] ta;
    fill_if_blank({y, x});
    if (regs.shade_mode[SM_TEXTURE]) begin
      ta = texel_word_addr(u, v);
      fill_if_blank(ta);
      if (regs.texture_depth != DEPTH_15) fill_if_blank(palette_addr(u, frame_words[ta]));
    end
    send_item(OP_DRAW, x, y, u, v, col, typed, typed_res);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_SHADE_MODE:    regs.shade_mode = val[3:0];
      REG_BLEND_OP:      regs.blend_op = val[1:0];
      REG_TEXTURE_DEPTH: regs.texture_depth = val[1:0];
      REG_TEXTURE_BASE:  regs.texture_base = val[18:0];
      REG_CLUT_BASE:     regs.clut_base = val[14:0];
      REG_WINDOW_MASK:   regs.window_mask = val[15:0];
      REG_LIGHT_COLOUR:  regs.light_colour = val;
      default:           regs.set_mask = val[0];
    endcase
  endtask

  // ------------------------------------------------------------------ checker
  always @(posedge clk) begin
    word_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result data %h stored %b", $time, out_data, out_stored);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_data !== e.data) begin
          $display("%0t: data expected %h actual %h", $time, e.data, out_data);
          errors++;
        end
        if (out_stored !== e.stored) begin
          $display("%0t: stored expected %b actual %b", $time, e.stored, out_stored);
          errors++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic stim_row_t item_row(op_t op, int x, int y, int u, int v, int col,
                                         bit typed = 0, int ed = 0, bit es = 0);
    return '{ROW_ITEM, op, 10'(x), 9'(y), 8'(u), 8'(v), 16'(col), 3'd0, 24'd0, typed,
             16'(ed), es};
  endfunction

  function automatic stim_row_t cfg_row(logic [2:0] idx, int val);
    return '{ROW_CFG, OP_NOP, 10'd0, 9'd0, 8'd0, 8'd0, 16'd0, idx, 24'(val), 1'b0, 16'd0,
             1'b0};
  endfunction

  initial begin
    stim_row_t   row;
    logic [23:0] vals [8];
    logic [23:0] maxes [8];
    int          k;
    maxes = '{24'hF, 24'h3, 24'h3, 24'h7FFFF, 24'h7FFF, 24'hFFFF, 24'hFFFFFF, 24'h1};
    regs = '{4'd1, BLEND_AVG, DEPTH_4, 19'd0, 15'd0, 16'hFFFF, 24'h808080, 1'b0};

    table_rows = '{
      item_row(OP_WRITE, 0, 0, 0, 0, 'hFFFF, 1, 'hFFFF, 1),
      item_row(OP_WRITE, 1023, 511, 255, 255, 0, 1, 0, 1),
      item_row(OP_READ, 0, 0, 0, 0, 0, 1, 'hFFFF, 0),
      item_row(OP_READ, 1023, 511, 0, 0, 'hFFFF, 1, 0, 0),
      item_row(OP_NOP, 1023, 511, 255, 255, 'hFFFF, 1, 0, 0),
      item_row(OP_DRAW, 0, 0, 0, 0, 'hFFFF, 1, 'h7FFF, 1),
      cfg_row(REG_SHADE_MODE, 0),
      item_row(OP_DRAW, 1, 0, 0, 0, 'h7FFF),
      cfg_row(REG_LIGHT_COLOUR, 'hFFFFFF),
      item_row(OP_DRAW, 2, 0, 0, 0, 'h4210),
      cfg_row(REG_LIGHT_COLOUR, 0),
      item_row(OP_DRAW, 3, 0, 0, 0, 'h7FFF),
      cfg_row(REG_SHADE_MODE, 3),
      item_row(OP_DRAW, 4, 0, 0, 0, 'h5A5A),
      cfg_row(REG_BLEND_OP, BLEND_ADD),
      item_row(OP_DRAW, 4, 0, 0, 0, 'h7FFF),
      cfg_row(REG_BLEND_OP, BLEND_SUB),
      item_row(OP_DRAW, 4, 0, 0, 0, 'h1234),
      cfg_row(REG_BLEND_OP, BLEND_QTR),
      item_row(OP_DRAW, 4, 0, 0, 0, 'hFFFF),
      cfg_row(REG_SHADE_MODE, 9),
      item_row(OP_WRITE, 5, 0, 0, 0, 'h8000, 1, 'h8000, 1),
      item_row(OP_DRAW, 5, 0, 0, 0, 'h7FFF, 1, 0, 0),        // mask check hit
      cfg_row(REG_SHADE_MODE, 5),
      cfg_row(REG_TEXTURE_BASE, 'h1000),
      cfg_row(REG_CLUT_BASE, 'h10),
      item_row(OP_WRITE, 0, 4, 0, 0, 0, 1, 0, 1),             // texel word, index 0
      item_row(OP_WRITE, 256, 0, 0, 0, 0, 1, 0, 1),           // palette entry 0
      item_row(OP_DRAW, 6, 0, 0, 0, 'h7FFF, 1, 0, 0),         // transparent texel
      item_row(OP_DRAW, 7, 0, 13, 9, 'h1111),
      cfg_row(REG_TEXTURE_DEPTH, DEPTH_8),
      item_row(OP_DRAW, 8, 0, 255, 255, 'h2222),
      cfg_row(REG_TEXTURE_DEPTH, DEPTH_15),
      cfg_row(REG_SHADE_MODE, 15),
      item_row(OP_WRITE, 3, 6, 0, 0, 'hFC1F, 1, 'hFC1F, 1),   // semi-transparent texel
      item_row(OP_WRITE, 9, 0, 0, 0, 'h0421, 1, 'h0421, 1),
      item_row(OP_DRAW, 9, 0, 3, 2, 0),
      cfg_row(REG_TEXTURE_DEPTH, DEPTH_4ALT),
      cfg_row(REG_SET_MASK, 1),
      cfg_row(REG_WINDOW_MASK, 'h0F0F),
      item_row(OP_DRAW, 10, 0, 'hF7, 'h1F, 0)
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (table_rows[i]) begin
      row = table_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.reg_idx, row.reg_val);
      end else if (row.op == OP_DRAW) begin
        send_draw(row.x, row.y, row.u, row.v, row.colour, row.typed,
                  '{row.edata, row.estored});
      end else begin
        send_item(row.op, row.x, row.y, row.u, row.v, row.colour, row.typed,
                  '{row.edata, row.estored});
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == PHASES - 1) gaps_on = 1'b0;
      for (int r = 0; r < 8; r++) begin
        if (ph == 0) vals[r] = maxes[r];
        else if (ph == 1) vals[r] = 24'd0;
        else vals[r] = 24'($urandom) & maxes[r];
        write_reg(3'(r), vals[r]);
      end
      // in some later passes cap each light channel at 9F so lit results stay varied
      if (ph > 2 && $urandom_range(0, 1) == 0)
        write_reg(REG_LIGHT_COLOUR, 24'($urandom) & 24'h9F9F9F);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        k = $urandom_range(0, 19);
        if (k < 3) begin
          if ($urandom_range(0, 3) == 0)
            send_item(OP_WRITE, 10'($urandom), 9'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom));
          else
            send_item(OP_WRITE, 10'($urandom_range(0, 31)), 9'($urandom_range(0, 7)),
                      8'($urandom), 8'($urandom), 16'($urandom));
        end else if (k < 5) begin
          k = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
          send_item(OP_READ, k[9:0], k[18:10], 8'($urandom), 8'($urandom), 16'($urandom));
        end else if (k == 5) begin
          send_item(OP_NOP, 10'($urandom), 9'($urandom), 8'($urandom), 8'($urandom),
                    16'($urandom));
        end else if ($urandom_range(0, 6) == 0) begin
          send_draw(10'($urandom), 9'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
        end else begin
          send_draw(10'($urandom_range(0, 31)), 9'($urandom_range(0, 7)), 8'($urandom),
                    8'($urandom), 16'($urandom));
        end
      end
    end

    wait_idle();
    if (errors == 0)
      $display("rgb555_pixel_shader_tb: done, clean");
    else
      $display("rgb555_pixel_shader_tb: done, errors");
    $finish;
  end

endmodule

### rgb555_pixel_shader.f
rtl/rps_pkg.sv
rtl/rps_front.sv
rtl/rps_back.sv
rtl/rgb555_pixel_shader.sv
verif/rgb555_pixel_shader_tb.sv
